FILE: src/finite_ring_set_intersect_union_top_assert.svh
// assertion macros for the set intersect/union block
// used by the top level only
`ifndef FINITE_RING_SET_INTERSECT_UNION_TOP_ASSERT_SVH
`define FINITE_RING_SET_INTERSECT_UNION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FRS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FRS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define FRS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: src/frsiu_pkg.sv
// shared types and codes for the set intersect/union block
// no dependencies
package frsiu_pkg;
  localparam logic [1:0] OP_LOAD1 = 2'd0;
  localparam logic [1:0] OP_LOAD2 = 2'd1;
  localparam logic [1:0] OP_INTER = 2'd2;
  localparam logic [1:0] OP_UNION = 2'd3;
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_SECOND = 2'd2;
  localparam logic [1:0] ST_NEW = 2'd3;
  // merge kinds run by the datapath
  typedef enum logic [1:0] {MK_UNION, MK_INTER, MK_MINUS} merge_e;
  // controller -> datapath commands
  typedef struct packed {
    logic    load_a;
    logic    load_b;
    logic    start;      // begin a compute
    logic    swap;       // a is second list
    logic    expand;     // expand the a-side? no: expand the complemented side
    logic    exp_a;      // expanded list replaces operand a
    logic    rc;
    merge_e  kind;
    logic    clear;
  } frsiu_cmd_t;
  typedef struct packed {
    logic busy;
    logic done;
  } frsiu_sts_t;
endpackage

FILE: src/finite_ring_set_intersect_union_top.sv
// top level of the two-set intersect/union block
// depends on frsiu_pkg, frsiu_ctrl, frsiu_dp and the assertion header
//
// Loads append to the first or second list (a full list ignores the load).
// A compute item walks the lists through registered memories, one compare
// per read round of the states P_MRD, P_MWT and P_MRG; when a complemented
// list is first expanded the ring walk steps through P_EXPRD and P_EXP for
// each ring value (ring size below RING_LIMIT). Each result item is then
// read back from the result memory through P_ORD, P_OWT and P_OUT, and may
// be held by an output stall. Both lists are cleared after the last item of
// a compute; the next item is accepted once the compute has finished.
`include "finite_ring_set_intersect_union_top_assert.svh"
module finite_ring_set_intersect_union_top import frsiu_pkg::*; #(
  parameter int SET_DEPTH = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int RING_LIMIT = 10000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [31:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [VALUE_WIDTH-1:0] element_i,
  input  logic                          first_complemented_i,
  input  logic                          second_complemented_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] result_value_o,
  output logic                          result_complemented_o,
  output logic [1:0]                    status_o,
  output logic                          no_element_o,
  output logic                          last_o
);
  localparam int CntW = $clog2(SET_DEPTH + 1) + 1;
  logic signed [31:0] ring_low_q, ring_high_q;
  logic signed [33:0] ring_m;
  logic [CntW-1:0] cnt1, cnt2;
  frsiu_cmd_t cmd;
  frsiu_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_low_q <= 32'sd0;
      ring_high_q <= 32'sd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i) ring_high_q <= cfg_data_i;
      else ring_low_q <= cfg_data_i;
    end
  end
  assign ring_m = 34'(ring_high_q) - 34'(ring_low_q) + 34'sd1;

  frsiu_ctrl #(.CntW(CntW), .RingLimit(RING_LIMIT)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i,
    .c1_i(first_complemented_i), .c2_i(second_complemented_i),
    .cnt1_i(cnt1), .cnt2_i(cnt2), .ring_m_i(ring_m), .sts_i(sts), .cmd_o(cmd));

  frsiu_dp #(.SetDepth(SET_DEPTH), .ValueWidth(VALUE_WIDTH), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .element_i, .ring_low_i(ring_low_q),
    .ring_high_i(ring_high_q), .ring_m_i(ring_m), .cnt1_o(cnt1), .cnt2_o(cnt2),
    .sts_o(sts), .out_valid_o, .out_ready_i, .result_value_o, .result_complemented_o,
    .status_o, .no_element_o, .last_o);

  `FRS_ASSERT_IMPL(a_no_out_when_ready, clk_i, rst_ni, in_ready_o, !out_valid_o)
  `FRS_ASSERT_IMPL(a_empty_is_last, clk_i, rst_ni, out_valid_o && no_element_o, last_o)
  `FRS_ASSERT_NEXT(a_cleared, clk_i, rst_ni, sts.done, cnt1 == '0 && cnt2 == '0)
endmodule

FILE: src/frsiu_ram.sv
// generic single write, single registered read ram
// no dependencies
module frsiu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/frsiu_ctrl.sv
// controller: decodes each item and picks the merge path
// depends on frsiu_pkg
module frsiu_ctrl import frsiu_pkg::*; #(
  parameter int CntW = 6,
  parameter int RingLimit = 10000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic              c1_i,
  input  logic              c2_i,
  input  logic [CntW-1:0]   cnt1_i,
  input  logic [CntW-1:0]   cnt2_i,
  input  logic signed [33:0] ring_m_i,
  input  frsiu_sts_t        sts_i,
  output frsiu_cmd_t        cmd_o
);
  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN = 1'b1;
  logic state_q, state_d;
  logic acc, is_int, ca, cb, mixed, may1, may2;
  logic signed [34:0] ap1, ap2;
  always_comb begin
    ap1 = 35'(ring_m_i) - 35'(cnt1_i);
    ap2 = 35'(ring_m_i) - 35'(cnt2_i);
    // guard checks list of the complemented side against the other list
    may1 = (ap1 >= 0) && (35'(cnt2_i) > ap1) && (ring_m_i < 34'(RingLimit));
    may2 = (ap2 >= 0) && (35'(cnt1_i) > ap2) && (ring_m_i < 34'(RingLimit));
  end
  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign is_int = (opcode_i == OP_INTER);
  always_comb begin
    cmd_o = '0;
    cmd_o.kind = MK_UNION;
    ca = c1_i;
    cb = c2_i;
    mixed = ca ^ cb;
    cmd_o.load_a = acc && (opcode_i == OP_LOAD1);
    cmd_o.load_b = acc && (opcode_i == OP_LOAD2);
    cmd_o.start = acc && opcode_i[1];
    if (!mixed) begin
      cmd_o.rc = ca;
      cmd_o.kind = ((is_int && !ca) || (!is_int && ca)) ? MK_INTER : MK_UNION;
    end else if (is_int) begin
      // plain side minus complemented side; plain side is a
      cmd_o.swap = ca;
      cmd_o.expand = ca ? may1 : may2;
      cmd_o.kind = cmd_o.expand ? MK_INTER : MK_MINUS;
      cmd_o.rc = 1'b0;
    end else begin
      // complemented side minus plain side; complemented side is a
      cmd_o.swap = cb;
      cmd_o.expand = cb ? may2 : may1;
      cmd_o.exp_a = 1'b1;
      cmd_o.kind = cmd_o.expand ? MK_UNION : MK_MINUS;
      cmd_o.rc = !cmd_o.expand;
    end
    cmd_o.clear = (state_q == S_RUN) && sts_i.done;
  end
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.start) state_d = S_RUN;
      S_RUN: if (sts_i.done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: src/frsiu_dp.sv
// datapath: list memories, expansion walk, merge engine and output stage
// depends on frsiu_pkg and frsiu_ram
module frsiu_dp import frsiu_pkg::*; #(
  parameter int SetDepth = 32,
  parameter int ValueWidth = 32,
  parameter int CntW = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  frsiu_cmd_t                   cmd_i,
  input  logic signed [ValueWidth-1:0] element_i,
  input  logic signed [31:0]           ring_low_i,
  input  logic signed [31:0]           ring_high_i,
  input  logic signed [33:0]           ring_m_i,
  output logic [CntW-1:0]              cnt1_o,
  output logic [CntW-1:0]              cnt2_o,
  output frsiu_sts_t                   sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ValueWidth-1:0] result_value_o,
  output logic                         result_complemented_o,
  output logic [1:0]                   status_o,
  output logic                         no_element_o,
  output logic                         last_o
);
  localparam int AW = (SetDepth > 1) ? $clog2(SetDepth) : 1;
  localparam int RD = 2 * SetDepth;
  localparam int RW = $clog2(RD) + 1;
  localparam int PW = CntW;

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_EXPRD = 4'd1;
  localparam logic [3:0] P_EXP = 4'd2;
  localparam logic [3:0] P_MRD = 4'd3;
  localparam logic [3:0] P_MWT = 4'd4;
  localparam logic [3:0] P_MRG = 4'd5;
  localparam logic [3:0] P_STAT = 4'd6;
  localparam logic [3:0] P_ORD = 4'd7;
  localparam logic [3:0] P_OWT = 4'd8;
  localparam logic [3:0] P_OUT = 4'd9;
  localparam logic [3:0] P_DONE = 4'd10;

  logic [3:0] ph_q, ph_d;
  logic [CntW-1:0] cnt1_q, cnt2_q;
  logic swap_q, expand_q, exp_a_q, rc_q;
  merge_e kind_q;
  logic [PW-1:0] na_q, nb_q, p1_q, p2_q, pe_q;
  logic [RW-1:0] pr_q, oi_q;
  logic j1_q, j2_q;
  logic signed [33:0] v_q;
  logic hit_q;
  logic [1:0] code_q;

  // memory ports
  logic we1, we2, wex, wres;
  logic [AW-1:0] wa1, wa2, ra1, ra2, waex, raex;
  logic [ValueWidth-1:0] rd1, rd2, rdex, rdres;
  logic [RW-2:0] wares, rares;
  logic [ValueWidth-1:0] wdres;

  assign cnt1_o = cnt1_q;
  assign cnt2_o = cnt2_q;

  assign we1 = cmd_i.load_a && (cnt1_q < CntW'(SetDepth));
  assign we2 = cmd_i.load_b && (cnt2_q < CntW'(SetDepth));
  assign wa1 = cnt1_q[AW-1:0];
  assign wa2 = cnt2_q[AW-1:0];

  // operand views: x is the list walked by pointer p1, y by p2
  logic [PW-1:0] nx, ny;
  logic [ValueWidth-1:0] ax, by, ex_src;
  logic [PW-1:0] ptr1, ptr2;
  logic [PW-1:0] cnt_s1, cnt_s2;
  assign cnt_s1 = swap_q ? cnt2_q : cnt1_q;
  assign cnt_s2 = swap_q ? cnt1_q : cnt2_q;

  frsiu_ram #(.Width(ValueWidth), .Depth(SetDepth)) u_l1 (
    .clk_i, .we_i(we1), .waddr_i(wa1), .wdata_i(element_i), .raddr_i(ra1), .rdata_o(rd1));
  frsiu_ram #(.Width(ValueWidth), .Depth(SetDepth)) u_l2 (
    .clk_i, .we_i(we2), .waddr_i(wa2), .wdata_i(element_i), .raddr_i(ra2), .rdata_o(rd2));
  frsiu_ram #(.Width(ValueWidth), .Depth(SetDepth)) u_ex (
    .clk_i, .we_i(wex), .waddr_i(waex), .wdata_i(v_q[ValueWidth-1:0]), .raddr_i(raex),
    .rdata_o(rdex));
  frsiu_ram #(.Width(ValueWidth), .Depth(RD)) u_res (
    .clk_i, .we_i(wres), .waddr_i(wares), .wdata_i(wdres), .raddr_i(rares),
    .rdata_o(rdres));

  // logical lists: s1 = swapped-first, s2 = swapped-second
  logic [ValueWidth-1:0] s1d, s2d;
  assign s1d = swap_q ? rd2 : rd1;
  assign s2d = swap_q ? rd1 : rd2;
  // the listed side of expansion is s2 (intersect) or s1 (union)
  assign ex_src = exp_a_q ? s1d : s2d;
  // x/y after expansion substitution
  assign ax = (expand_q && exp_a_q) ? rdex : s1d;
  assign by = (expand_q && !exp_a_q) ? rdex : s2d;
  assign nx = (expand_q && exp_a_q) ? pe_q : cnt_s1;
  assign ny = (expand_q && !exp_a_q) ? pe_q : cnt_s2;

  // addressing: during expansion p1 walks the listed side
  always_comb begin
    ptr1 = p1_q;
    ptr2 = p2_q;
    ra1 = AW'(swap_q ? ptr2 : ptr1);
    ra2 = AW'(swap_q ? ptr1 : ptr2);
    if (ph_q == P_EXPRD || ph_q == P_EXP) begin
      // reuse pointer p1 for the listed side
      if (exp_a_q ^ swap_q) begin
        ra1 = AW'(p1_q);
      end else begin
        ra2 = AW'(p1_q);
      end
    end
    raex = AW'(exp_a_q ? p1_q : p2_q);
  end
  assign rares = oi_q[RW-2:0];

  logic signed [ValueWidth-1:0] sa, sb, se;
  assign sa = ax;
  assign sb = by;
  assign se = ex_src;

  logic pa, pb;
  assign pa = p1_q < nx;
  assign pb = p2_q < ny;

  always_comb begin
    wex = 1'b0;
    waex = AW'(pe_q);
    wres = 1'b0;
    wares = pr_q[RW-2:0];
    wdres = sa;
    if (ph_q == P_EXP && v_q <= 34'(ring_high_i)) begin
      if (!(p1_q < (exp_a_q ? cnt_s1 : cnt_s2) && 34'(se) == v_q)) begin
        wex = pe_q < PW'(SetDepth);
      end
    end
    if (ph_q == P_MRG) begin
      unique case (kind_q)
        MK_UNION: begin
          wres = pa || pb;
          wdres = (pa && (!pb || sa <= sb)) ? sa : sb;
        end
        MK_INTER: begin
          wres = pa && pb && sa == sb;
          wdres = sa;
        end
        MK_MINUS: begin
          wres = pa && (!pb || sa < sb) && !hit_q && !(pb && sa == sb);
          wdres = sa;
        end
        default: begin
          wres = 1'b0;
        end
      endcase
    end
  end

  // merge step and pointer moves (one comparison per read round of P_MRD, P_MWT and P_MRG)
  logic [1:0] st_raw, st_fix;
  logic empty;
  always_comb begin
    st_raw = {j2_q, j1_q};
    if (kind_q == MK_MINUS) begin
      st_raw = {1'b0, RW'(pr_q) == RW'(nx)};
    end
    // undo the swap of the status bits
    st_fix = swap_q ? {st_raw[0], st_raw[1]} : st_raw;
    empty = (!rc_q && pr_q == '0) || (rc_q && ring_m_i == 34'(pr_q));
  end

  always_comb begin
    ph_d = ph_q;
    unique case (ph_q)
      P_IDLE: if (cmd_i.start) ph_d = P_EXPRD;
      P_EXPRD: ph_d = expand_q ? P_EXP : P_MRD;
      P_EXP: ph_d = (v_q > 34'(ring_high_i)) ? P_MRD : P_EXPRD;
      P_MRD: ph_d = P_MWT;
      P_MWT: ph_d = P_MRG;
      P_MRG: ph_d = (!pa || (!pb && kind_q != MK_UNION) ||
                     (kind_q == MK_UNION && !pa && !pb)) ? P_STAT : P_MRD;
      P_STAT: ph_d = P_ORD;
      P_ORD: ph_d = P_OWT;
      P_OWT: ph_d = P_OUT;
      P_OUT: if (out_ready_i) ph_d = last_o ? P_DONE : P_ORD;
      P_DONE: ph_d = P_IDLE;
      default: ph_d = P_IDLE;
    endcase
    if (ph_q == P_MRG && kind_q == MK_UNION) begin
      ph_d = (pa || pb) ? P_MRD : P_STAT;
    end
    if (ph_q == P_MRG && kind_q == MK_MINUS) begin
      ph_d = pa ? P_MRD : P_STAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= P_IDLE;
      cnt1_q <= '0;
      cnt2_q <= '0;
    end else begin
      ph_q <= ph_d;
      if (we1) cnt1_q <= cnt1_q + 1'b1;
      if (we2) cnt2_q <= cnt2_q + 1'b1;
      if (ph_q == P_DONE) begin
        cnt1_q <= '0;
        cnt2_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ph_q)
      P_IDLE: begin
        swap_q <= cmd_i.swap;
        expand_q <= cmd_i.expand;
        exp_a_q <= cmd_i.exp_a;
        rc_q <= cmd_i.rc;
        kind_q <= cmd_i.kind;
        p1_q <= '0;
        p2_q <= '0;
        pe_q <= '0;
        pr_q <= '0;
        oi_q <= '0;
        j1_q <= 1'b1;
        j2_q <= 1'b1;
        hit_q <= 1'b0;
        v_q <= 34'(ring_low_i);
      end
      P_EXP: begin
        if (v_q <= 34'(ring_high_i)) begin
          if (p1_q < (exp_a_q ? cnt_s1 : cnt_s2) && 34'(se) == v_q) begin
            p1_q <= p1_q + 1'b1;
          end else if (pe_q < PW'(SetDepth)) begin
            pe_q <= pe_q + 1'b1;
          end
          v_q <= v_q + 34'sd1;
        end else begin
          p1_q <= '0;
        end
      end
      P_MRG: begin
        unique case (kind_q)
          MK_UNION: begin
            if (pa && pb) begin
              if (sa < sb) begin
                p1_q <= p1_q + 1'b1; j2_q <= 1'b0;
              end else if (sa > sb) begin
                p2_q <= p2_q + 1'b1; j1_q <= 1'b0;
              end else begin
                p1_q <= p1_q + 1'b1; p2_q <= p2_q + 1'b1;
              end
            end else if (pa) begin
              p1_q <= p1_q + 1'b1; j2_q <= 1'b0;
            end else if (pb) begin
              p2_q <= p2_q + 1'b1; j1_q <= 1'b0;
            end
            if (pa || pb) pr_q <= pr_q + 1'b1;
          end
          MK_INTER: begin
            if (!pa || !pb) begin
              // empty-list rules or leftovers
              if (nx != '0 && ny != '0) begin
                if (pa) j1_q <= 1'b0;
                if (pb) j2_q <= 1'b0;
              end else begin
                j1_q <= (nx == '0);
                j2_q <= (ny == '0);
              end
            end else if (sa > sb) begin
              p2_q <= p2_q + 1'b1; j2_q <= 1'b0;
            end else if (sa < sb) begin
              p1_q <= p1_q + 1'b1; j1_q <= 1'b0;
            end else begin
              p1_q <= p1_q + 1'b1; p2_q <= p2_q + 1'b1; pr_q <= pr_q + 1'b1;
            end
          end
          MK_MINUS: begin
            if (pa) begin
              if (pb && sa > sb) begin
                p2_q <= p2_q + 1'b1;
                if (sa == sb) hit_q <= 1'b1;
              end else begin
                // element settled: hit covers an equal entry at p2
                if (wres) pr_q <= pr_q + 1'b1;
                p1_q <= p1_q + 1'b1;
                hit_q <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      P_STAT: begin
        if (empty) code_q <= ST_EMPTY;
        else if (st_fix[0]) code_q <= ST_FIRST;
        else if (st_fix[1]) code_q <= ST_SECOND;
        else code_q <= ST_NEW;
      end
      P_OUT: begin
        if (out_ready_i) oi_q <= oi_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic none;
  assign none = (pr_q == '0);
  assign out_valid_o = (ph_q == P_OUT);
  assign result_value_o = none ? '0 : rdres;
  assign result_complemented_o = rc_q;
  assign status_o = code_q;
  assign no_element_o = none;
  assign last_o = none || (oi_q + 1'b1 == pr_q);
  assign sts_o.busy = (ph_q != P_IDLE);
  assign sts_o.done = (ph_q == P_DONE);
endmodule
